// ===== src/lcfe_pkg.sv =====
// shared types and constants of the led color fade engine
package lcfe_pkg;

   // command codes
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_SET_COLOR = 3'd1;
   localparam logic [2:0] CMD_SET_FADE  = 3'd2;
   localparam logic [2:0] CMD_STOP_FADE = 3'd3;
   localparam logic [2:0] CMD_SIGNAL_OK = 3'd4;

   // signal ok fade
   localparam logic [7:0]  CHAN_MASK   = 8'hFF;
   localparam logic [7:0]  OK_GREEN    = 8'd150;
   localparam logic [15:0] OK_DURATION = 16'd300;

   // width of the led number carried between controller and datapath
   localparam int LED_W = 6;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  led_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] duration_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [5:0] pixel_index;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] start_color;
      logic [23:0] target_color;
      logic [31:0] start_time;
      logic [15:0] duration;
   } fade_rec_type;

   // controller to datapath
   typedef struct packed {
      logic             req_load;
      logic             sel_req;
      logic [LED_W-1:0] led;
      logic             pix_rd;
      logic             pix_wr_req;
      logic             pix_wr_target;
      logic             pix_wr_blend;
      logic             fade_rd;
      logic             fade_wr;
      logic             act_set;
      logic             act_clr;
      logic [1:0]       chan;
      logic             mul_load;
      logic             div_step;
      logic [2:0]       div_bit;
      logic             chan_done;
      logic             out_load;
      logic             out_last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] command;
      logic       idx_ok;
      logic       active;
      logic       expired;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== src/lcfe_ram.sv =====
// generic single write port ram with registered read
module lcfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== src/lcfe_datapath.sv =====
// datapath: pixel and fade stores, blend multiplier, shared divider, output register
module lcfe_datapath #(
   parameter int NUM_LEDS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lcfe_pkg::req_type       req,
   output lcfe_pkg::rsp_type       rsp,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  lcfe_pkg::dp_cmd_type    cmd,
   output lcfe_pkg::dp_status_type status
);
   import lcfe_pkg::*;

   localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   req_type          req_ff;
   logic [AW-1:0]    addr;
   logic [NUM_LEDS-1:0] active_ff;
   logic [NUM_LEDS-1:0] pix_valid_ff;
   logic             pix_valid_q_ff;
   logic             pix_wr;
   logic [23:0]      pix_wr_data;
   logic [23:0]      pix_q;
   logic [23:0]      pix_color;
   fade_rec_type     fade_wr_data;
   fade_rec_type     fade_q;
   logic [31:0]      elapsed;
   logic [7:0]       s_chan;
   logic [7:0]       t_chan;
   logic [7:0]       diff;
   logic             neg_ff;
   logic [7:0]       base_ff;
   logic [23:0]      rem_ff;
   logic [7:0]       quo_ff;
   logic [23:0]      trial;
   logic [7:0]       quo_up;
   logic [7:0]       chan_res;
   logic [23:0]      blend_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req;
      end
   end

   assign addr = cmd.sel_req ? req_ff.led_index[AW-1:0] : cmd.led[AW-1:0];

   // fade active flags and pixel valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         pix_valid_ff <= '0;
      end else begin
         if (cmd.act_set) begin
            active_ff[addr] <= 1'b1;
         end else if (cmd.act_clr) begin
            active_ff[addr] <= 1'b0;
         end
         if (pix_wr) begin
            pix_valid_ff[addr] <= 1'b1;
         end
      end
   end

   // pixel store
   assign pix_wr = cmd.pix_wr_req | cmd.pix_wr_target | cmd.pix_wr_blend;
   always_comb begin
      if (cmd.pix_wr_req) begin
         pix_wr_data = {req_ff.red, req_ff.green, req_ff.blue};
      end else if (cmd.pix_wr_target) begin
         pix_wr_data = fade_q.target_color;
      end else begin
         pix_wr_data = blend_ff;
      end
   end

   lcfe_ram #(.WIDTH(24), .DEPTH(NUM_LEDS)) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_wr),
      .wr_addr (addr),
      .wr_data (pix_wr_data),
      .rd_en   (cmd.pix_rd),
      .rd_addr (addr),
      .rd_data (pix_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.pix_rd) begin
         pix_valid_q_ff <= pix_valid_ff[addr];
      end
   end

   // never written pixels read as off
   assign pix_color = pix_valid_q_ff ? pix_q : 24'd0;

   // fade record store
   always_comb begin
      fade_wr_data.start_color = pix_color;
      fade_wr_data.start_time  = req_ff.now_ms;
      if (req_ff.command == CMD_SIGNAL_OK) begin
         fade_wr_data.target_color = {8'd0, OK_GREEN & CHAN_MASK, 8'd0};
         fade_wr_data.duration     = OK_DURATION;
      end else begin
         fade_wr_data.target_color = {req_ff.red, req_ff.green, req_ff.blue};
         fade_wr_data.duration     = req_ff.duration_ms;
      end
   end

   lcfe_ram #(.WIDTH($bits(fade_rec_type)), .DEPTH(NUM_LEDS)) u_fade_ram (
      .clock   (clock),
      .wr_en   (cmd.fade_wr),
      .wr_addr (addr),
      .wr_data (fade_wr_data),
      .rd_en   (cmd.fade_rd),
      .rd_addr (addr),
      .rd_data (fade_q)
   );

   // elapsed time and end of fade
   assign elapsed = req_ff.now_ms - fade_q.start_time;

   // channel select
   always_comb begin
      case (cmd.chan)
         2'd0: begin
            s_chan = fade_q.start_color[23:16];
            t_chan = fade_q.target_color[23:16];
         end
         2'd1: begin
            s_chan = fade_q.start_color[15:8];
            t_chan = fade_q.target_color[15:8];
         end
         default: begin
            s_chan = fade_q.start_color[7:0];
            t_chan = fade_q.target_color[7:0];
         end
      endcase
   end

   assign diff = (t_chan < s_chan) ? (s_chan - t_chan) : (t_chan - s_chan);

   // multiply then restoring divide, one quotient bit a cycle
   assign trial = {8'd0, fade_q.duration} << cmd.div_bit;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         neg_ff  <= t_chan < s_chan;
         base_ff <= s_chan;
         rem_ff  <= {16'd0, diff} * {8'd0, elapsed[15:0]};
         quo_ff  <= 8'd0;
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff              <= rem_ff - trial;
            quo_ff[cmd.div_bit] <= 1'b1;
         end
      end
   end

   // floor toward minus infinity on a falling channel
   assign quo_up   = quo_ff + {7'd0, (rem_ff != 24'd0)};
   assign chan_res = neg_ff ? (base_ff - quo_up) : (base_ff + quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.chan_done) begin
         case (cmd.chan)
            2'd0:    blend_ff[23:16] <= chan_res;
            2'd1:    blend_ff[15:8]  <= chan_res;
            default: blend_ff[7:0]   <= chan_res;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.pixel_index <= cmd.led;
         rsp_ff.out_red     <= pix_color[23:16];
         rsp_ff.out_green   <= pix_color[15:8];
         rsp_ff.out_blue    <= pix_color[7:0];
         rsp_ff.frame_last  <= cmd.out_last;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // status back to the controller
   assign status.command  = req_ff.command;
   assign status.idx_ok   = req_ff.led_index < 8'(NUM_LEDS);
   assign status.active   = active_ff[addr];
   assign status.expired  = elapsed >= {16'd0, fade_q.duration};
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
endmodule

// ===== src/lcfe_controller.sv =====
// controller: sequences commands, the per-led fade update and the strip output
module lcfe_controller #(
   parameter int NUM_LEDS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output lcfe_pkg::dp_cmd_type    cmd,
   input  lcfe_pkg::dp_status_type status
);
   import lcfe_pkg::*;

   localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [AW-1:0] LAST_LED = AW'(NUM_LEDS - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_FADE_WR  = 4'd2;
   localparam logic [3:0] S_UPD_RD   = 4'd3;
   localparam logic [3:0] S_UPD_CHK  = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_CHAN     = 4'd7;
   localparam logic [3:0] S_UPD_WR   = 4'd8;
   localparam logic [3:0] S_EMIT_RD  = 4'd9;
   localparam logic [3:0] S_EMIT_OUT = 4'd10;
   localparam logic [3:0] S_DRAIN    = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] led_ff, led_in;
   logic [1:0]    chan_ff, chan_in;
   logic [2:0]    bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         led_ff   <= '0;
         chan_ff  <= 2'd0;
         bit_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         led_ff   <= led_in;
         chan_ff  <= chan_in;
         bit_ff   <= bit_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      led_in   = led_ff;
      chan_in  = chan_ff;
      bit_in   = bit_ff;
      cmd          = '0;
      cmd.led      = LED_W'(led_ff);
      cmd.chan     = chan_ff;
      cmd.div_bit  = bit_ff;
      cmd.out_last = led_ff == LAST_LED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.sel_req = 1'b1;
            led_in      = '0;
            state_in    = S_IDLE;
            case (status.command)
               CMD_TICK: begin
                  state_in = S_UPD_RD;
               end
               CMD_SET_COLOR: begin
                  if (status.idx_ok) begin
                     cmd.pix_wr_req = 1'b1;
                     state_in       = S_EMIT_RD;
                  end
               end
               CMD_SET_FADE, CMD_SIGNAL_OK: begin
                  if (status.idx_ok) begin
                     cmd.pix_rd = 1'b1;
                     state_in   = S_FADE_WR;
                  end
               end
               CMD_STOP_FADE: begin
                  cmd.act_clr = status.idx_ok;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FADE_WR: begin
            cmd.sel_req = 1'b1;
            cmd.fade_wr = 1'b1;
            cmd.act_set = 1'b1;
            state_in    = S_IDLE;
         end
         S_UPD_RD: begin
            if (status.active) begin
               cmd.fade_rd = 1'b1;
               state_in    = S_UPD_CHK;
            end else if (led_ff == LAST_LED) begin
               led_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               led_in = led_ff + 1'b1;
            end
         end
         S_UPD_CHK: begin
            chan_in = 2'd0;
            if (status.expired) begin
               cmd.pix_wr_target = 1'b1;
               cmd.act_clr       = 1'b1;
               if (led_ff == LAST_LED) begin
                  led_in   = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  led_in   = led_ff + 1'b1;
                  state_in = S_UPD_RD;
               end
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            bit_in       = 3'd7;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == 3'd0) begin
               state_in = S_CHAN;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_CHAN: begin
            cmd.chan_done = 1'b1;
            if (chan_ff == 2'd2) begin
               state_in = S_UPD_WR;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_UPD_WR: begin
            cmd.pix_wr_blend = 1'b1;
            if (led_ff == LAST_LED) begin
               led_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               led_in   = led_ff + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.pix_rd = 1'b1;
            state_in   = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (led_ff == LAST_LED) begin
                  state_in = S_DRAIN;
               end else begin
                  led_in   = led_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_DRAIN: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ===== src/led_color_fade_engine.sv =====
// top level of the led color fade engine
// one request at a time; req_stall is high from acceptance until the command ends, for tick
// and set color when the last pixel is taken. tick: take and decode, skip idle leds, write the
// target of ended fades, blend the 3 channels of fading leds, then output each led and drain.
// set color also outputs the strip; set fade, signal ok write a fade record; stop fade ends it.
// synchronous active-high reset clears pixels to off, all fades inactive, no output.
module led_color_fade_engine #(
   parameter int NUM_LEDS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcfe_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcfe_pkg::rsp_type rsp
);
   import lcfe_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   lcfe_controller #(.NUM_LEDS(NUM_LEDS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // storage and arithmetic
   lcfe_datapath #(.NUM_LEDS(NUM_LEDS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );
endmodule

// ===== src/lcfe_checker.sv =====
// port checker for the led color fade engine and its bind
module lcfe_checker #(
   parameter int NUM_LEDS = 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lcfe_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lcfe_pkg::rsp_type rsp
);
   import lcfe_pkg::*;

   // the last pixel of a frame carries the highest index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.frame_last |-> rsp.pixel_index == 6'(NUM_LEDS - 1))
      else $error("frame_last on wrong pixel");

   // no new request while a pixel is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while output pending");

   // an accepted request makes the block busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after request");

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled output changed");
endmodule

bind led_color_fade_engine lcfe_checker #(.NUM_LEDS(NUM_LEDS)) u_lcfe_checker (.*);
